// ===== hw/rtl/lla_pkg.sv =====
`timescale 1ns / 1ps

package lla_pkg;

    localparam int MODE_W     = 2;
    localparam int COORD_W    = 6;
    localparam int MASK_W     = 9;
    localparam int SIZE_W     = 7;
    localparam int SUM_W      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = MASK_W;

    localparam logic [MODE_W-1:0] MODE_WRITE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ADVANCE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NOP     = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_BIRTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SURVIVE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COLS    = 2'd3;

    localparam logic [MASK_W-1:0] BIRTH_RST   = 9'd8;
    localparam logic [MASK_W-1:0] SURVIVE_RST = 9'd12;
    localparam logic [SIZE_W-1:0] ROWS_RST    = 7'd64;
    localparam logic [SIZE_W-1:0] COLS_RST    = 7'd64;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               cell_in;
    } t_item;

    typedef struct packed {
        logic cell_out;
        logic range_error;
    } t_result;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CELL_RD,
        ST_CELL_FIN,
        ST_ADV_UP,
        ST_ADV_MID,
        ST_ADV_DN,
        ST_ADV_WR
    } t_state;

    typedef struct packed {
        logic clear_step;
        logic accept;
        logic cell_fin;
        logic adv_up;
        logic adv_mid;
        logic adv_dn;
        logic adv_wr;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_last;
        logic row_last;
        logic in_adv;
    } t_dp_sts;

endpackage

// ===== hw/rtl/lla_ram.sv =====
`timescale 1ns / 1ps

module lla_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/lla_ctrl.sv =====
`timescale 1ns / 1ps

module lla_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  lla_pkg::t_dp_sts i_sts,
    output lla_pkg::t_dp_cmd o_cmd,
    output logic             o_busy
);

    import lla_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_sts.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_start) begin
                    n_state = i_sts.in_adv ? ST_ADV_UP : ST_CELL_RD;
                end
            end
            ST_CELL_RD:  n_state = ST_CELL_FIN;
            ST_CELL_FIN: n_state = ST_IDLE;
            ST_ADV_UP:   n_state = ST_ADV_MID;
            ST_ADV_MID:  n_state = ST_ADV_DN;
            ST_ADV_DN:   n_state = ST_ADV_WR;
            ST_ADV_WR: begin
                n_state = i_sts.row_last ? ST_IDLE : ST_ADV_UP;
            end
            default:     n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        unique case (r_state)
            ST_CLEAR:    o_cmd.clear_step = 1'b1;
            ST_IDLE: begin
                o_busy       = 1'b0;
                o_cmd.accept = i_start;
            end
            ST_CELL_RD:  o_cmd = '0;
            ST_CELL_FIN: o_cmd.cell_fin = 1'b1;
            ST_ADV_UP:   o_cmd.adv_up = 1'b1;
            ST_ADV_MID:  o_cmd.adv_mid = 1'b1;
            ST_ADV_DN:   o_cmd.adv_dn = 1'b1;
            ST_ADV_WR:   o_cmd.adv_wr = 1'b1;
            default:     o_cmd = '0;
        endcase
    end

endmodule

// ===== hw/rtl/lla_dpath.sv =====
`timescale 1ns / 1ps

module lla_dpath #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  lla_pkg::t_item                   i_item,
    input  logic                             i_cfg_we,
    input  logic [lla_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [lla_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  lla_pkg::t_dp_cmd                 i_cmd,
    output lla_pkg::t_dp_sts                 o_sts,
    output logic                             o_done,
    output lla_pkg::t_result                 o_result
);

    import lla_pkg::*;

    localparam int ROW_AW = $clog2(MAX_ROWS);
    localparam int COL_AW = $clog2(MAX_COLS);
    localparam int SW_R   = ($clog2(MAX_ROWS + 1) > SIZE_W) ? $clog2(MAX_ROWS + 1) : SIZE_W;
    localparam int SW_C   = ($clog2(MAX_COLS + 1) > SIZE_W) ? $clog2(MAX_COLS + 1) : SIZE_W;

    logic [MASK_W-1:0] r_birth;
    logic [MASK_W-1:0] r_survive;
    logic [SIZE_W-1:0] r_rows;
    logic [SIZE_W-1:0] r_cols;

    t_item             r_item;
    logic              r_err;
    logic [ROW_AW-1:0] r_row;
    logic              r_bank;
    logic              r_done;
    t_result           r_res;
    logic [MAX_COLS-1:0] r_up;
    logic [MAX_COLS-1:0] r_mid;

    logic [SW_R-1:0]   rows_ext;
    logic [SW_C-1:0]   cols_ext;
    logic [SW_R-1:0]   h;
    logic [SW_C-1:0]   w;
    logic              in_cell;
    logic              out_of_range;
    logic [ROW_AW-1:0] row_idx;
    logic [COL_AW-1:0] col_idx;
    logic [ROW_AW-1:0] up_idx;
    logic [ROW_AW-1:0] dn_idx;
    logic [ROW_AW-1:0] cur_raddr;
    logic [COL_AW-1:0] w_m1;
    logic              cell_we;
    logic              last_row_wr;

    logic                we_a;
    logic                we_b;
    logic [ROW_AW-1:0]   waddr_a;
    logic [ROW_AW-1:0]   waddr_b;
    logic [MAX_COLS-1:0] wdata_a;
    logic [MAX_COLS-1:0] wdata_b;
    logic [ROW_AW-1:0]   raddr_a;
    logic [ROW_AW-1:0]   raddr_b;
    logic [MAX_COLS-1:0] rdata_a;
    logic [MAX_COLS-1:0] rdata_b;
    logic [MAX_COLS-1:0] cur_rdata;
    logic [MAX_COLS-1:0] nxt_rdata;
    logic [MAX_COLS-1:0] cell_row;
    logic [MAX_COLS-1:0] new_row;
    logic                up_w;
    logic                mid_w;
    logic                dn_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_birth   <= BIRTH_RST;
            r_survive <= SURVIVE_RST;
            r_rows    <= ROWS_RST;
            r_cols    <= COLS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_BIRTH:   r_birth   <= i_cfg_data[MASK_W-1:0];
                REG_SURVIVE: r_survive <= i_cfg_data[MASK_W-1:0];
                REG_ROWS:    r_rows    <= i_cfg_data[SIZE_W-1:0];
                REG_COLS:    r_cols    <= i_cfg_data[SIZE_W-1:0];
                default:     r_rows    <= r_rows;
            endcase
        end
    end

    assign rows_ext = SW_R'(r_rows);
    assign cols_ext = SW_C'(r_cols);
    assign h = (rows_ext == '0) ? SW_R'(1) :
               (rows_ext > SW_R'(MAX_ROWS)) ? SW_R'(MAX_ROWS) : rows_ext;
    assign w = (cols_ext == '0) ? SW_C'(1) :
               (cols_ext > SW_C'(MAX_COLS)) ? SW_C'(MAX_COLS) : cols_ext;

    assign in_cell      = (i_item.mode == MODE_WRITE) || (i_item.mode == MODE_READ);
    assign out_of_range = (SW_R'(i_item.row) >= h) || (SW_C'(i_item.col) >= w);

    assign row_idx = ROW_AW'(r_item.row);
    assign col_idx = COL_AW'(r_item.col);
    assign up_idx  = (r_row == '0) ? ROW_AW'(h - SW_R'(1)) : r_row - ROW_AW'(1);
    assign dn_idx  = ((SW_R'(r_row) + SW_R'(1)) >= h) ? '0 : r_row + ROW_AW'(1);
    assign w_m1    = COL_AW'(w - SW_C'(1));

    assign last_row_wr = i_cmd.adv_wr && o_sts.row_last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_item <= i_item;
            r_err  <= in_cell && out_of_range;
        end
        if (i_cmd.adv_mid) begin
            r_up <= cur_rdata;
        end
        if (i_cmd.adv_dn) begin
            r_mid <= cur_rdata;
        end
        if (i_cmd.cell_fin) begin
            r_res.cell_out    <= (r_item.mode == MODE_READ) && !r_err && cur_rdata[col_idx];
            r_res.range_error <= r_err;
        end else if (last_row_wr) begin
            r_res <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_bank <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.cell_fin || last_row_wr;
            if (i_cmd.accept) begin
                r_row <= '0;
            end else if (i_cmd.clear_step || (i_cmd.adv_wr && !o_sts.row_last)) begin
                r_row <= r_row + ROW_AW'(1);
            end
            if (last_row_wr) begin
                r_bank <= !r_bank;
            end
        end
    end

    assign o_sts.clear_last = (r_row == ROW_AW'(MAX_ROWS - 1));
    assign o_sts.row_last   = (SW_R'(r_row) == (h - SW_R'(1)));
    assign o_sts.in_adv     = (i_item.mode == MODE_ADVANCE);

    assign cur_rdata = r_bank ? rdata_b : rdata_a;
    assign nxt_rdata = r_bank ? rdata_a : rdata_b;

    always_comb begin
        cell_row          = cur_rdata;
        cell_row[col_idx] = r_item.cell_in;
    end

    always_comb begin
        priority if (i_cmd.adv_up) begin
            cur_raddr = up_idx;
        end else if (i_cmd.adv_mid) begin
            cur_raddr = r_row;
        end else if (i_cmd.adv_dn) begin
            cur_raddr = dn_idx;
        end else begin
            cur_raddr = row_idx;
        end
    end

    assign cell_we = i_cmd.cell_fin && (r_item.mode == MODE_WRITE) && !r_err;

    assign raddr_a = r_bank ? r_row : cur_raddr;
    assign raddr_b = r_bank ? cur_raddr : r_row;

    assign we_a    = i_cmd.clear_step || (r_bank ? i_cmd.adv_wr : cell_we);
    assign we_b    = i_cmd.clear_step || (r_bank ? cell_we : i_cmd.adv_wr);
    assign waddr_a = (!r_bank && cell_we) ? row_idx : r_row;
    assign waddr_b = (r_bank && cell_we) ? row_idx : r_row;
    assign wdata_a = i_cmd.clear_step ? '0 : (r_bank ? new_row : cell_row);
    assign wdata_b = i_cmd.clear_step ? '0 : (r_bank ? cell_row : new_row);

    assign up_w  = r_up[w_m1];
    assign mid_w = r_mid[w_m1];
    assign dn_w  = cur_rdata[w_m1];

    for (genvar c = 0; c < MAX_COLS; c++) begin : g_lane
        logic             ul;
        logic             ur;
        logic             ml;
        logic             mr;
        logic             dl;
        logic             dr;
        logic [SUM_W-1:0] s;

        if (c == 0) begin : g_left_edge
            assign ul = up_w;
            assign ml = mid_w;
            assign dl = dn_w;
        end else begin : g_left
            assign ul = r_up[c-1];
            assign ml = r_mid[c-1];
            assign dl = cur_rdata[c-1];
        end

        if (c == MAX_COLS - 1) begin : g_right_edge
            assign ur = r_up[0];
            assign mr = r_mid[0];
            assign dr = cur_rdata[0];
        end else begin : g_right
            assign ur = (SW_C'(c + 1) >= w) ? r_up[0] : r_up[c+1];
            assign mr = (SW_C'(c + 1) >= w) ? r_mid[0] : r_mid[c+1];
            assign dr = (SW_C'(c + 1) >= w) ? cur_rdata[0] : cur_rdata[c+1];
        end

        assign s = SUM_W'(ul) + SUM_W'(r_up[c]) + SUM_W'(ur) + SUM_W'(ml) + SUM_W'(mr)
                 + SUM_W'(dl) + SUM_W'(cur_rdata[c]) + SUM_W'(dr);

        assign new_row[c] = (SW_C'(c) < w) ? (r_mid[c] ? r_survive[s] : r_birth[s])
                                           : nxt_rdata[c];
    end

    lla_ram #(
        .WIDTH (MAX_COLS),
        .DEPTH (MAX_ROWS)
    ) u_bank_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (waddr_a),
        .i_wdata (wdata_a),
        .i_raddr (raddr_a),
        .o_rdata (rdata_a)
    );

    lla_ram #(
        .WIDTH (MAX_COLS),
        .DEPTH (MAX_ROWS)
    ) u_bank_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (waddr_b),
        .i_wdata (wdata_b),
        .i_raddr (raddr_b),
        .o_rdata (rdata_b)
    );

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

// ===== hw/rtl/life_like_automaton_step_unit.sv =====
// Cell write, cell read and no-op: busy through CELL_RD and CELL_FIN after the transfer,
// result strobe on the return to idle, next transfer possible in that cycle.
// Advance: one row of cells per ADV_UP/MID/DN/WR pass through the single read port of
// the current bank; busy for one pass per row in use, result strobe in the cycle after.
// Reset: synchronous; a clearing pass over all MAX_ROWS rows zeroes both banks, busy high.
// The receiver cannot stall: each result strobe is high for exactly one cycle.
`timescale 1ns / 1ps

module life_like_automaton_step_unit #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  lla_pkg::t_item                 i_item,
    input  logic                           i_cfg_we,
    input  logic [lla_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lla_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                           o_done,
    output lla_pkg::t_result               o_result
);

    import lla_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    lla_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    lla_dpath #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_done     (o_done),
        .o_result   (o_result)
    );

endmodule

// ===== hw/rtl/lla_checker.sv =====
`timescale 1ns / 1ps

module lla_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic             o_done,
    input lla_pkg::t_result o_result
);

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy low after an input transfer");

    a_done_follows_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy) && !busy)
        else $error("result strobe without preceding work");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe on consecutive cycles");

    a_clear_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> busy)
        else $error("block idle before the clearing pass");

    a_error_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.range_error |-> !o_result.cell_out)
        else $error("cell value returned with a range error");

endmodule

bind life_like_automaton_step_unit lla_checker u_lla_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);
